// ----- rtl/imurf_pkg.sv -----
// Shared definitions for the inertial sensor register file.
// Op codes, register map, scaling constants and tables; no dependencies.
package imurf_pkg;

  typedef enum logic [2:0] {
    OP_ADDRESS   = 3'd0,
    OP_SET_PTR   = 3'd1,
    OP_WRITE_REG = 3'd2,
    OP_READ_BYTE = 3'd3,
    OP_LOAD      = 3'd4
  } op_t;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS    = 1'b0;
  localparam logic CFG_DEVICE_RESPONDING = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;

  // register map
  localparam logic [7:0] REG_RATE_DIV   = 8'h19;
  localparam logic [7:0] REG_FILTER     = 8'h1A;
  localparam logic [7:0] REG_GYRO_RANGE = 8'h1B;
  localparam logic [7:0] REG_ACCEL_RNG  = 8'h1C;
  localparam logic [7:0] REG_PWR_ONE    = 8'h6B;
  localparam logic [7:0] REG_PWR_TWO    = 8'h6C;
  localparam logic [7:0] REG_ID         = 8'h75;
  localparam logic [7:0] REG_DATA_FIRST = 8'h3B;
  localparam logic [7:0] REG_DATA_LAST  = 8'h48;

  localparam logic [7:0] ID_VALUE        = 8'h68;
  localparam logic [7:0] PWR_ONE_RESET   = 8'h40;
  localparam logic [18:0] ACCEL_Z_RESET  = 19'd16384;
  localparam logic [15:0] TEMP_RESET     = 16'd6400;

  // temp raw = (1700*T - 15897856) / 1280, division done as >>8 then /5
  localparam logic [10:0] TEMP_FACTOR    = 11'd1700;
  localparam logic signed [31:0] TEMP_OFFSET = 32'sd15897856;
  localparam logic [3:0]  TEMP_SHIFT     = 4'd8;
  // gyro raw = g*K / 2560, division done as >>9 then /5
  localparam logic [3:0]  GYRO_SHIFT     = 4'd9;

  // floor(x/5) = (x*RECIP5) >> 18, exact for x below 2**18
  localparam logic [15:0] RECIP5         = 16'd52429;
  localparam int          RECIP5_SHIFT   = 18;
  // clamping to 5*32769 keeps every saturation decision intact
  localparam logic [17:0] DIV5_CLAMP     = 18'd163845;
  localparam logic [15:0] MAG_CLAMP      = 16'd32769;

  function automatic logic [10:0] gyro_factor(input logic [1:0] sel);
    logic [10:0] f;
    unique case (sel)
      2'd0: f = 11'd1310;
      2'd1: f = 11'd655;
      2'd2: f = 11'd328;
      2'd3: f = 11'd164;
      default: f = 11'd1310;
    endcase
    return f;
  endfunction

  // carried from the select stage to the scaling stage
  typedef struct packed {
    logic        ack;
    logic        is_data;
    logic        high_byte;
    logic        neg;
    logic        div5;
    logic [31:0] mag;
    logic [7:0]  direct;
  } mid_t;

endpackage

// ----- rtl/imu_i2c_register_file.sv -----
// Top level of the inertial sensor register file: bus actions in, ack/read byte out.
// Depends on imurf_pkg for op codes, the register map and scaling constants.

// One request enters per clock when the output side keeps up; each produces exactly
// one result, offered on m_tdata after it has passed through three
// registers (input register, select/multiply stage, divide-by-five and saturate stage).
// The single 20x12 multiplier in the select stage and the reciprocal multiply in the
// scaling stage set the stage lengths. Settings, pointer and samples update as a
// request leaves the input register, so every read sees the effect of all earlier
// requests. A stalled output holds each stage in turn.
module imu_i2c_register_file (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: bus_address[6:0], register_index[14:7], write_value[22:15],
  //   accel_x_in[41:23], accel_y_in[60:42], accel_z_in[79:61], gyro_x_in[99:80],
  //   gyro_y_in[119:100], gyro_z_in[139:120], temperature_in[155:140], zero[159:156]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic [2:0]   s_tuser,   // op[2:0]
  // m_tdata: ack[0], read_data[8:1], zero[15:9]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // configuration
  logic [6:0] device_address;
  logic       device_responding;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= imurf_pkg::DEVICE_ADDRESS_RESET;
      device_responding <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        imurf_pkg::CFG_DEVICE_ADDRESS:    device_address    <= pwdata[6:0];
        imurf_pkg::CFG_DEVICE_RESPONDING: device_responding <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      imurf_pkg::CFG_DEVICE_ADDRESS:    prdata = {25'd0, device_address};
      imurf_pkg::CFG_DEVICE_RESPONDING: prdata = {31'd0, device_responding};
      default:                          prdata = 32'd0;
    endcase
  end

  // pipeline handshake
  logic in_valid, mid_valid;
  logic adv_out, adv_mid, adv_in, fire_in;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv_mid  = !mid_valid || adv_out;
  assign adv_in   = !in_valid || adv_mid;
  assign s_tready = adv_in;
  assign fire_in  = in_valid && adv_mid;

  // input register
  logic [2:0]   in_op;
  logic [155:0] in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= s_tvalid;
    end
    if (adv_in && s_tvalid) begin
      in_op   <= s_tuser;
      in_data <= s_tdata[155:0];
    end
  end

  logic [6:0]  f_bus_address;
  logic [7:0]  f_register_index;
  logic [7:0]  f_write_value;
  assign f_bus_address    = in_data[6:0];
  assign f_register_index = in_data[14:7];
  assign f_write_value    = in_data[22:15];

  // device state
  logic [7:0]  pointer_base, read_offset;
  logic [7:0]  rate_divider_setting, filter_setting;
  logic [7:0]  gyro_range_setting, accel_range_setting;
  logic [7:0]  power_control_one, power_control_two;
  logic [18:0] accel_sample [3];
  logic [19:0] gyro_sample [3];
  logic [15:0] temperature_sample;

  logic addr_match;
  assign addr_match = (f_bus_address == device_address) && device_responding;

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_base         <= 8'd0;
      read_offset          <= 8'd0;
      rate_divider_setting <= 8'd0;
      filter_setting       <= 8'd0;
      gyro_range_setting   <= 8'd0;
      accel_range_setting  <= 8'd0;
      power_control_one    <= imurf_pkg::PWR_ONE_RESET;
      power_control_two    <= 8'd0;
      accel_sample[0]      <= 19'd0;
      accel_sample[1]      <= 19'd0;
      accel_sample[2]      <= imurf_pkg::ACCEL_Z_RESET;
      gyro_sample[0]       <= 20'd0;
      gyro_sample[1]       <= 20'd0;
      gyro_sample[2]       <= 20'd0;
      temperature_sample   <= imurf_pkg::TEMP_RESET;
    end else if (fire_in) begin
      unique case (in_op)
        imurf_pkg::OP_ADDRESS: begin
          if (addr_match) read_offset <= 8'd0;
        end
        imurf_pkg::OP_SET_PTR: begin
          pointer_base <= f_register_index;
          read_offset  <= 8'd0;
        end
        imurf_pkg::OP_WRITE_REG: begin
          pointer_base <= f_register_index;
          unique case (f_register_index)
            imurf_pkg::REG_RATE_DIV:   rate_divider_setting <= f_write_value;
            imurf_pkg::REG_FILTER:     filter_setting       <= f_write_value;
            imurf_pkg::REG_GYRO_RANGE: gyro_range_setting   <= f_write_value;
            imurf_pkg::REG_ACCEL_RNG:  accel_range_setting  <= f_write_value;
            imurf_pkg::REG_PWR_ONE:    power_control_one    <= f_write_value;
            imurf_pkg::REG_PWR_TWO:    power_control_two    <= f_write_value;
            default: ;
          endcase
        end
        imurf_pkg::OP_READ_BYTE: begin
          read_offset <= read_offset + 8'd1;
        end
        imurf_pkg::OP_LOAD: begin
          accel_sample[0]    <= in_data[41:23];
          accel_sample[1]    <= in_data[60:42];
          accel_sample[2]    <= in_data[79:61];
          gyro_sample[0]     <= in_data[99:80];
          gyro_sample[1]     <= in_data[119:100];
          gyro_sample[2]     <= in_data[139:120];
          temperature_sample <= in_data[155:140];
        end
        default: ;
      endcase
    end
  end

  // select stage: pick the source value and run numerator = value*factor - offset
  logic [7:0]         rd_addr, k;
  logic               rd_is_data;
  logic [19:0]        operand;
  logic [10:0]        factor;
  logic signed [31:0] offset, num;
  logic [3:0]         shift;
  logic [31:0]        abs_num;
  logic [7:0]         direct;
  imurf_pkg::mid_t    mid, mid_next;

  assign rd_addr    = pointer_base + read_offset;
  assign k          = rd_addr - imurf_pkg::REG_DATA_FIRST;
  assign rd_is_data = (rd_addr >= imurf_pkg::REG_DATA_FIRST) &&
                      (rd_addr <= imurf_pkg::REG_DATA_LAST);

  always_comb begin
    operand = 20'd0;
    factor  = 11'd1;
    offset  = 32'sd0;
    shift   = {2'b00, accel_range_setting[4:3]};
    if (k < 8'd6) begin
      operand = {accel_sample[k[2:1]][18], accel_sample[k[2:1]]};
    end else if (k < 8'd8) begin
      operand = {{4{temperature_sample[15]}}, temperature_sample};
      factor  = imurf_pkg::TEMP_FACTOR;
      offset  = imurf_pkg::TEMP_OFFSET;
      shift   = imurf_pkg::TEMP_SHIFT;
    end else begin
      // gyro entries are k = 8..13, sample index (k-8)>>1
      operand = gyro_sample[2'(k[3:1] - 3'd4)];
      factor  = imurf_pkg::gyro_factor(gyro_range_setting[4:3]);
      shift   = imurf_pkg::GYRO_SHIFT;
    end
  end

  assign num     = $signed(operand) * $signed({1'b0, factor}) - offset;
  assign abs_num = num[31] ? 32'(-num) : 32'(num);

  always_comb begin
    unique case (rd_addr)
      imurf_pkg::REG_RATE_DIV:   direct = rate_divider_setting;
      imurf_pkg::REG_FILTER:     direct = filter_setting;
      imurf_pkg::REG_GYRO_RANGE: direct = gyro_range_setting;
      imurf_pkg::REG_ACCEL_RNG:  direct = accel_range_setting;
      imurf_pkg::REG_PWR_ONE:    direct = power_control_one;
      imurf_pkg::REG_PWR_TWO:    direct = power_control_two;
      imurf_pkg::REG_ID:         direct = imurf_pkg::ID_VALUE;
      default:                   direct = 8'd0;
    endcase
  end

  always_comb begin
    mid_next.ack       = (in_op == imurf_pkg::OP_ADDRESS) && addr_match;
    mid_next.is_data   = (in_op == imurf_pkg::OP_READ_BYTE) && rd_is_data;
    mid_next.high_byte = !k[0];
    mid_next.neg       = num[31];
    mid_next.div5      = (k >= 8'd6);
    mid_next.mag       = abs_num >> shift;
    mid_next.direct    = (in_op == imurf_pkg::OP_READ_BYTE) ? direct : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (adv_mid) begin
      mid_valid <= in_valid;
    end
    if (fire_in) begin
      mid <= mid_next;
    end
  end

  // scaling stage: divide by five where needed, saturate, take the byte
  logic [17:0] x5;
  logic [33:0] prod5;
  logic [15:0] m_mag;
  logic [15:0] raw;
  logic [7:0]  read_byte;

  assign x5    = (mid.mag > 32'(imurf_pkg::DIV5_CLAMP)) ? imurf_pkg::DIV5_CLAMP :
                 mid.mag[17:0];
  assign prod5 = x5 * imurf_pkg::RECIP5;

  always_comb begin
    if (mid.div5) begin
      m_mag = prod5[imurf_pkg::RECIP5_SHIFT +: 16];
    end else if (mid.mag > 32'(imurf_pkg::MAG_CLAMP)) begin
      m_mag = imurf_pkg::MAG_CLAMP;
    end else begin
      m_mag = mid.mag[15:0];
    end
    if (mid.neg) begin
      raw = (m_mag > 16'd32768) ? 16'h8000 : 16'(-m_mag);
    end else begin
      raw = (m_mag > 16'd32767) ? 16'h7FFF : m_mag;
    end
    if (mid.is_data) begin
      read_byte = mid.high_byte ? raw[15:8] : raw[7:0];
    end else begin
      read_byte = mid.direct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= mid_valid;
    end
    if (adv_out && mid_valid) begin
      m_tdata <= {7'd0, read_byte, mid.ack};
    end
  end

endmodule
